/* rtl/core/kel_pkg.sv */
// Shared types, codes and defaults for the key event latch with typematic repeat.
package kel_pkg;

  localparam int DELTA_WIDTH_DEF = 8;
  localparam int TIMER_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 4;
  localparam int DELAY_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_SIZE_RST       = 4'd1;
  localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST   = 16'd350;
  localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RST = 16'd60;

  typedef enum logic [1:0] {
    REQ_KEY     = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_CONSUME = 2'd2
  } req_type_t;

  localparam logic [2:0] KEY_PWR      = 3'd0;
  localparam logic [2:0] KEY_PLAY     = 3'd1;
  localparam logic [2:0] KEY_NEXT     = 3'd2;
  localparam logic [2:0] KEY_PREV     = 3'd3;
  localparam logic [2:0] KEY_VOL_UP   = 3'd4;
  localparam logic [2:0] KEY_VOL_DOWN = 3'd5;

  localparam logic [1:0] KEY_VAL_UP   = 2'd0;
  localparam logic [1:0] KEY_VAL_DOWN = 2'd1;

  localparam int MASK_POWER  = 0;
  localparam int MASK_PLAY   = 1;
  localparam int MASK_NEXT   = 2;
  localparam int MASK_PREV   = 3;
  localparam int MASK_VOLUME = 4;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] key_code;
    logic [1:0] key_value;
    logic [4:0] consume_mask;
  } item_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_size;
    logic [DELAY_W-1:0] initial_delay;
    logic [DELAY_W-1:0] repeat_interval;
  } cfg_t;

  typedef struct packed {
    logic power_pending;
    logic play_pending;
    logic next_pending;
    logic prev_pending;
    logic any_volume_held;
  } flags_t;

endpackage

/* rtl/core/key_event_latch_typematic.sv */
// Top level: input register, latch update, result register and config port.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | tuser req_type, tdata key/mask fields
//   out_    | out | out_tvalid/out_tready| tdata pending flags, volume, held
//   cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; a beat's result reaches
// out_tdata through the input register, then the result register.
// State updates as a beat moves from the input register to the result register.
// A stalled output holds the result register; the input register still takes
// one more beat, then in_tready drops until the output drains.
// Reset clears both registers' valid bits, the latch state and loads config defaults.
module key_event_latch_typematic
  import kel_pkg::*;
#(
  parameter int DELTA_WIDTH = DELTA_WIDTH_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
  localparam int OUT_W      = ((DELTA_WIDTH + 5 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // key_code[2:0], key_value[4:3], consume_mask[9:5]
  input  logic [1:0]            in_tuser,   // req_type[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // power, play, next, prev, volume_change, any_volume_held from bit 0 up
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RES_W = DELTA_WIDTH + 5;

  logic                   in_valid_r, in_valid_nxt;
  item_t                  in_item_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r;
  logic                   adv;
  cfg_t                   cfg;
  flags_t                 flags;
  logic [DELTA_WIDTH-1:0] volume_change;
  logic [RES_W-1:0]       res_bits;

  assign cfg_ready = 1'b1;

  kel_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  kel_core #(
    .DELTA_WIDTH (DELTA_WIDTH),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (adv),
    .item          (in_item_r),
    .cfg           (cfg),
    .flags         (flags),
    .volume_change (volume_change)
  );

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (adv) in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign res_bits = {flags.any_volume_held, volume_change, flags.prev_pending,
                     flags.next_pending, flags.play_pending, flags.power_pending};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.req_type     <= in_tuser;
      in_item_r.key_code     <= in_tdata[2:0];
      in_item_r.key_value    <= in_tdata[4:3];
      in_item_r.consume_mask <= in_tdata[9:5];
    end
    if (adv) begin
      out_data_r <= {{(OUT_W-RES_W){1'b0}}, res_bits};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result register not loaded after advance");

  a_stall_keeps_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |=> in_valid_r)
    else $error("input register dropped a beat under stall");

  a_unmasked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_item_r.req_type == REQ_CONSUME && !in_item_r.consume_mask[MASK_POWER])
      |=> !out_data_r[0])
    else $error("unselected power flag reported on consume");

endmodule

/* rtl/core/kel_cfg.sv */
// Configuration register file: step size, initial delay and repeat interval.
module kel_cfg
  import kel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_STEP_SIZE:       cfg_nxt.step_size       = wr_data[STEP_W-1:0];
        CFG_INITIAL_DELAY:   cfg_nxt.initial_delay   = wr_data[DELAY_W-1:0];
        CFG_REPEAT_INTERVAL: cfg_nxt.repeat_interval = wr_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_size       <= STEP_SIZE_RST;
      cfg_r.initial_delay   <= INITIAL_DELAY_RST;
      cfg_r.repeat_interval <= REPEAT_INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/kel_core.sv */
// Latch state, typematic countdowns and per-item update with saturating volume sum.
module kel_core
  import kel_pkg::*;
#(
  parameter int DELTA_WIDTH = DELTA_WIDTH_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  item_t                  item,
  input  cfg_t                   cfg,
  output flags_t                 flags,
  output logic [DELTA_WIDTH-1:0] volume_change
);

  localparam int SW = DELTA_WIDTH + 5;
  localparam logic signed [SW-1:0] DMAX = $signed({6'b0, {(DELTA_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] DMIN = -DMAX - SW'(1);

  logic                   power_r, power_nxt;
  logic                   play_r, play_nxt;
  logic                   next_r, next_nxt;
  logic                   prev_r, prev_nxt;
  logic [DELTA_WIDTH-1:0] vol_r, vol_nxt;
  logic                   up_held_r, up_held_nxt;
  logic                   dn_held_r, dn_held_nxt;
  logic [TIMER_WIDTH-1:0] up_cnt_r, up_cnt_nxt;
  logic [TIMER_WIDTH-1:0] dn_cnt_r, dn_cnt_nxt;

  logic [TIMER_WIDTH+DELAY_W-1:0] delay_ext;
  logic [TIMER_WIDTH+DELAY_W-1:0] rep_ext;
  logic [TIMER_WIDTH-1:0]         delay_t;
  logic [TIMER_WIDTH-1:0]         rep_t;
  logic                           up_fire;
  logic                           dn_fire;
  logic [DELTA_WIDTH-1:0]         vol_mid;

  function automatic logic [DELTA_WIDTH-1:0] sat_step(
    input logic [DELTA_WIDTH-1:0] v,
    input logic                   sub,
    input logic [STEP_W-1:0]      s
  );
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] sum;
    a   = $signed({{5{v[DELTA_WIDTH-1]}}, v});
    b   = $signed({{(DELTA_WIDTH+1){1'b0}}, s});
    sum = sub ? (a - b) : (a + b);
    if (sum > DMAX) sum = DMAX;
    if (sum < DMIN) sum = DMIN;
    return sum[DELTA_WIDTH-1:0];
  endfunction

  assign delay_ext = {{TIMER_WIDTH{1'b0}}, cfg.initial_delay};
  assign rep_ext   = {{TIMER_WIDTH{1'b0}}, cfg.repeat_interval};
  assign delay_t   = delay_ext[TIMER_WIDTH-1:0];
  assign rep_t     = rep_ext[TIMER_WIDTH-1:0];

  // countdown of 0 or 1 is due
  assign up_fire = up_held_r && (up_cnt_r[TIMER_WIDTH-1:1] == '0);
  assign dn_fire = dn_held_r && (dn_cnt_r[TIMER_WIDTH-1:1] == '0);

  always_comb begin
    power_nxt   = power_r;
    play_nxt    = play_r;
    next_nxt    = next_r;
    prev_nxt    = prev_r;
    vol_nxt     = vol_r;
    up_held_nxt = up_held_r;
    dn_held_nxt = dn_held_r;
    up_cnt_nxt  = up_cnt_r;
    dn_cnt_nxt  = dn_cnt_r;
    vol_mid     = vol_r;

    case (item.req_type)
      REQ_KEY: begin
        if (item.key_value == KEY_VAL_DOWN) begin
          case (item.key_code)
            KEY_PWR:   power_nxt = 1'b1;
            KEY_PLAY:  play_nxt  = 1'b1;
            KEY_NEXT:  next_nxt  = 1'b1;
            KEY_PREV:  prev_nxt  = 1'b1;
            KEY_VOL_UP: begin
              vol_nxt     = sat_step(vol_r, 1'b0, cfg.step_size);
              up_held_nxt = 1'b1;
              up_cnt_nxt  = delay_t;
            end
            KEY_VOL_DOWN: begin
              vol_nxt     = sat_step(vol_r, 1'b1, cfg.step_size);
              dn_held_nxt = 1'b1;
              dn_cnt_nxt  = delay_t;
            end
            default: ;
          endcase
        end else if (item.key_value == KEY_VAL_UP) begin
          if (item.key_code == KEY_VOL_UP) up_held_nxt = 1'b0;
          else if (item.key_code == KEY_VOL_DOWN) dn_held_nxt = 1'b0;
        end
      end
      REQ_TICK: begin
        if (up_held_r) up_cnt_nxt = up_fire ? rep_t : up_cnt_r - TIMER_WIDTH'(1);
        if (dn_held_r) dn_cnt_nxt = dn_fire ? rep_t : dn_cnt_r - TIMER_WIDTH'(1);
        // up step lands before down step
        vol_mid = up_fire ? sat_step(vol_r, 1'b0, cfg.step_size) : vol_r;
        vol_nxt = dn_fire ? sat_step(vol_mid, 1'b1, cfg.step_size) : vol_mid;
      end
      REQ_CONSUME: begin
        if (item.consume_mask[MASK_POWER])  power_nxt = 1'b0;
        if (item.consume_mask[MASK_PLAY])   play_nxt  = 1'b0;
        if (item.consume_mask[MASK_NEXT])   next_nxt  = 1'b0;
        if (item.consume_mask[MASK_PREV])   prev_nxt  = 1'b0;
        if (item.consume_mask[MASK_VOLUME]) vol_nxt   = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    flags.any_volume_held = up_held_nxt || dn_held_nxt;
    if (item.req_type == REQ_CONSUME) begin
      flags.power_pending = item.consume_mask[MASK_POWER] & power_r;
      flags.play_pending  = item.consume_mask[MASK_PLAY]  & play_r;
      flags.next_pending  = item.consume_mask[MASK_NEXT]  & next_r;
      flags.prev_pending  = item.consume_mask[MASK_PREV]  & prev_r;
      volume_change       = item.consume_mask[MASK_VOLUME] ? vol_r : '0;
    end else begin
      flags.power_pending = power_nxt;
      flags.play_pending  = play_nxt;
      flags.next_pending  = next_nxt;
      flags.prev_pending  = prev_nxt;
      volume_change       = vol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r   <= 1'b0;
      play_r    <= 1'b0;
      next_r    <= 1'b0;
      prev_r    <= 1'b0;
      vol_r     <= '0;
      up_held_r <= 1'b0;
      dn_held_r <= 1'b0;
      up_cnt_r  <= '0;
      dn_cnt_r  <= '0;
    end else if (fire) begin
      power_r   <= power_nxt;
      play_r    <= play_nxt;
      next_r    <= next_nxt;
      prev_r    <= prev_nxt;
      vol_r     <= vol_nxt;
      up_held_r <= up_held_nxt;
      dn_held_r <= dn_held_nxt;
      up_cnt_r  <= up_cnt_nxt;
      dn_cnt_r  <= dn_cnt_nxt;
    end
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for key_event_latch_typematic: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import kel_pkg::*;

  localparam logic [1:0]           REQ_RSVD     = 2'd3;
  localparam logic [2:0]           KEY_BAD      = 3'd7;
  localparam logic [1:0]           KEY_VAL_AUTO = 2'd2;
  localparam logic [1:0]           KEY_VAL_RSVD = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

  localparam logic [4:0] MASK_ALL      = 5'h1f;
  localparam logic [4:0] CONS_PWR_NEXT = 5'((1 << MASK_POWER) | (1 << MASK_NEXT));
  localparam logic [4:0] CONS_REST     = 5'((1 << MASK_PLAY) | (1 << MASK_PREV) |
                                            (1 << MASK_VOLUME));

  localparam int VOL_MAX      = (1 << (DELTA_WIDTH_DEF - 1)) - 1;
  localparam int VOL_MIN      = -VOL_MAX - 1;
  localparam int PHASE_ITEMS  = 200;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_AT      = 900;
  localparam int CYCLE_LIMIT  = 200000;

  // out_tdata from bit 0 up: power, play, next, prev, volume_change, any_volume_held
  typedef struct packed {
    logic       held;
    logic [7:0] vol;
    logic       prev;
    logic       next;
    logic       play;
    logic       power;
  } result_t;

  localparam result_t RES_ZERO = '0;

  // register rows carry the register index in req
  typedef struct packed {
    logic        is_reg;
    logic [1:0]  req;
    logic [2:0]  code;
    logic [1:0]  kval;
    logic [4:0]  mask;
    logic [15:0] reg_val;
    logic        typed;
    result_t     want;
  } stim_row_t;

  localparam stim_row_t DIRECTED [0:29] = '{
    '{1'b0, REQ_CONSUME, KEY_PWR,      KEY_VAL_UP,   MASK_ALL,      16'd0, 1'b1, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_PWR,      KEY_VAL_DOWN, 5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_PLAY,     KEY_VAL_DOWN, 5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_NEXT,     KEY_VAL_DOWN, 5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_PREV,     KEY_VAL_DOWN, 5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_PWR,      KEY_VAL_UP,   5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_BAD,      KEY_VAL_DOWN, 5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_VOL_UP,   KEY_VAL_AUTO, 5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_VOL_UP,   KEY_VAL_DOWN, 5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_VOL_DOWN, KEY_VAL_RSVD, 5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_RSVD,    KEY_VOL_UP,   KEY_VAL_DOWN, MASK_ALL,      16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_CONSUME, KEY_PWR,      KEY_VAL_UP,   CONS_PWR_NEXT, 16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_CONSUME, KEY_PWR,      KEY_VAL_UP,   CONS_REST,     16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_VOL_UP,   KEY_VAL_UP,   5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b1, CFG_STEP_SIZE,       3'd0, 2'd0,         5'd0,          16'd15, 1'b0, RES_ZERO},
    '{1'b1, CFG_INITIAL_DELAY,   3'd0, 2'd0,         5'd0,          16'd0,  1'b0, RES_ZERO},
    '{1'b1, CFG_REPEAT_INTERVAL, 3'd0, 2'd0,         5'd0,          16'd0,  1'b0, RES_ZERO},
    '{1'b0, REQ_KEY,     KEY_VOL_UP,   KEY_VAL_DOWN, 5'd0, 16'd0, 1'b1, {1'b1, 8'd15, 4'd0}},
    '{1'b0, REQ_TICK,    KEY_PWR,      KEY_VAL_UP,   5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_TICK,    KEY_PWR,      KEY_VAL_UP,   5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_TICK,    KEY_PWR,      KEY_VAL_UP,   5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_TICK,    KEY_PWR,      KEY_VAL_UP,   5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_TICK,    KEY_PWR,      KEY_VAL_UP,   5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_TICK,    KEY_PWR,      KEY_VAL_UP,   5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_TICK,    KEY_PWR,      KEY_VAL_UP,   5'd0,          16'd0, 1'b0, RES_ZERO},
    '{1'b0, REQ_TICK,    KEY_PWR,      KEY_VAL_UP,   5'd0, 16'd0, 1'b1, {1'b1, 8'd127, 4'd0}},
    '{1'b0, REQ_KEY,     KEY_VOL_DOWN, KEY_VAL_DOWN, 5'd0, 16'd0, 1'b1, {1'b1, 8'd112, 4'd0}},
    '{1'b0, REQ_KEY,     KEY_VOL_UP,   KEY_VAL_DOWN, 5'd0, 16'd0, 1'b1, {1'b1, 8'd127, 4'd0}},
    '{1'b0, REQ_TICK,    KEY_PWR,      KEY_VAL_UP,   5'd0, 16'd0, 1'b1, {1'b1, 8'd112, 4'd0}},
    '{1'b0, REQ_CONSUME, KEY_PWR,      KEY_VAL_UP,   MASK_ALL, 16'd0, 1'b1, {1'b1, 8'd112, 4'd0}}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // latch state mirror
  int         step_q     = STEP_SIZE_RST;
  int         delay_q    = INITIAL_DELAY_RST;
  int         interval_q = REPEAT_INTERVAL_RST;
  logic [3:0] req_flags  = '0;
  int         vol_acc    = 0;
  logic       key_held [2] = '{1'b0, 1'b0};  // 0 volume up, 1 volume down
  int         key_cnt  [2] = '{0, 0};

  result_t latch_reports [$];
  logic    calm         = 1'b0;
  logic    held_off     = 1'b0;
  int      beats_in     = 0;
  int      reports_seen = 0;
  int      mismatches   = 0;
  int      repeat_steps = 0;
  int      clamped      = 0;
  int      settings     = 1;

  key_event_latch_typematic DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp_vol(input int v);
    if (v > VOL_MAX || v < VOL_MIN) clamped++;
    return (v > VOL_MAX) ? VOL_MAX : (v < VOL_MIN) ? VOL_MIN : v;
  endfunction

  function automatic logic idle_now();
    return !calm && ($urandom_range(99) < 23);
  endfunction

  task automatic latch_step(input logic [1:0] rt, input logic [2:0] kc, input logic [1:0] kv,
                            input logic [4:0] cm, output result_t r);
    logic [3:0] shown_flags;
    int         shown_vol;
    shown_flags = '0;
    shown_vol   = 0;
    case (rt)
      REQ_KEY: begin
        if (kv == KEY_VAL_DOWN) begin
          case (kc)
            KEY_PWR:   req_flags[MASK_POWER] = 1'b1;
            KEY_PLAY:  req_flags[MASK_PLAY]  = 1'b1;
            KEY_NEXT:  req_flags[MASK_NEXT]  = 1'b1;
            KEY_PREV:  req_flags[MASK_PREV]  = 1'b1;
            KEY_VOL_UP: begin
              vol_acc     = clamp_vol(vol_acc + step_q);
              key_held[0] = 1'b1;
              key_cnt[0]  = delay_q;
            end
            KEY_VOL_DOWN: begin
              vol_acc     = clamp_vol(vol_acc - step_q);
              key_held[1] = 1'b1;
              key_cnt[1]  = delay_q;
            end
            default: ;
          endcase
        end else if (kv == KEY_VAL_UP) begin
          if (kc == KEY_VOL_UP) key_held[0] = 1'b0;
          else if (kc == KEY_VOL_DOWN) key_held[1] = 1'b0;
        end
      end
      REQ_TICK: begin
        // up key steps before down key
        for (int k = 0; k < 2; k++) begin
          if (key_held[k]) begin
            if (key_cnt[k] <= 1) begin
              key_cnt[k] = interval_q;
              vol_acc    = clamp_vol(vol_acc + ((k == 0) ? step_q : -step_q));
              repeat_steps++;
            end else begin
              key_cnt[k]--;
            end
          end
        end
      end
      default: ;
    endcase
    if (rt == REQ_CONSUME) begin
      for (int b = MASK_POWER; b <= MASK_PREV; b++) begin
        if (cm[b]) begin
          shown_flags[b] = req_flags[b];
          req_flags[b]   = 1'b0;
        end
      end
      if (cm[MASK_VOLUME]) begin
        shown_vol = vol_acc;
        vol_acc   = 0;
      end
    end else begin
      shown_flags = req_flags;
      shown_vol   = vol_acc;
    end
    r.power = shown_flags[MASK_POWER];
    r.play  = shown_flags[MASK_PLAY];
    r.next  = shown_flags[MASK_NEXT];
    r.prev  = shown_flags[MASK_PREV];
    r.vol   = shown_vol[7:0];
    r.held  = key_held[0] | key_held[1];
  endtask

  // entered and left at a falling edge; leaves in_tvalid high
  task automatic send_item(input logic [1:0] rt, input logic [2:0] kc, input logic [1:0] kv,
                           input logic [4:0] cm, input logic typed, input result_t want);
    result_t r;
    while (idle_now()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rt;
    in_tdata  <= {6'd0, cm, kv, kc};
    do @(posedge clk); while (!in_tready);
    beats_in++;
    latch_step(rt, kc, kv, cm, r);
    latch_reports.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STEP_SIZE:       step_q     = data[STEP_W-1:0];
      CFG_INITIAL_DELAY:   delay_q    = data;
      CFG_REPEAT_INTERVAL: interval_q = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (latch_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : report_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      reports_seen++;
      if (latch_reports.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat %h with none outstanding", $time, out_tdata);
      end else begin
        want = latch_reports.pop_front();
        check_field("power_pending", want.power, out_tdata[0]);
        check_field("play_pending", want.play, out_tdata[1]);
        check_field("next_pending", want.next, out_tdata[2]);
        check_field("prev_pending", want.prev, out_tdata[3]);
        check_field("volume_change", $signed(want.vol), $signed(out_tdata[11:4]));
        check_field("any_volume_held", want.held, out_tdata[12]);
        check_field("tdata pad", 0, out_tdata[15:13]);
      end
    end
  end

  initial begin : result_sink
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && reports_seen >= HOLD_AT) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= !idle_now();
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int         stp, dly, ivl, pick;
    logic [1:0] rt;
    logic [2:0] kc;
    logic [1:0] kv;
    logic [4:0] cm;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].is_reg) begin
        if (i == 0 || !DIRECTED[i-1].is_reg) settle();
        write_reg(DIRECTED[i].req, DIRECTED[i].reg_val);
        if (!DIRECTED[i+1].is_reg) begin
          cfg_valid <= 1'b0;
          settings++;
        end
      end else begin
        send_item(DIRECTED[i].req, DIRECTED[i].code, DIRECTED[i].kval, DIRECTED[i].mask,
                  DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        1: begin stp = 15; dly = 0; ivl = 0; end
        2: begin stp = 0; dly = 16'hffff; ivl = 16'hffff; end
        5: begin
          stp = $urandom_range(1, 15);
          dly = $urandom_range(20, 40);
          ivl = $urandom_range(5, 10);
        end
        7: begin stp = 15; dly = 1; ivl = 1; end
        default: begin
          stp = $urandom_range(15);
          dly = $urandom_range(8);
          ivl = $urandom_range(4);
        end
      endcase
      // upper step bits are don't-care in the register
      write_reg(CFG_STEP_SIZE, CFG_DATA_W'(($urandom_range(16'hffff) & 16'hfff0) | stp));
      write_reg(CFG_INITIAL_DELAY, CFG_DATA_W'(dly));
      write_reg(CFG_REPEAT_INTERVAL, CFG_DATA_W'(ivl));
      if (ph == 3) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(16'hffff)));
      cfg_valid <= 1'b0;
      settings++;
      calm = (ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rt   = 2'($urandom_range(3));
        kc   = 3'($urandom_range(7));
        kv   = 2'($urandom_range(3));
        cm   = 5'($urandom_range(31));
        pick = $urandom_range(99);
        if (pick < 45) begin
          rt = REQ_TICK;
        end else if (pick < 72) begin
          rt = REQ_KEY;
          if ($urandom_range(9) < 7) kc = $urandom_range(1) ? KEY_VOL_UP : KEY_VOL_DOWN;
          if ($urandom_range(19) == 0) kv = 2'($urandom_range(KEY_VAL_AUTO, KEY_VAL_RSVD));
          else kv = ($urandom_range(9) < 6) ? KEY_VAL_DOWN : KEY_VAL_UP;
        end else if (pick < 88) begin
          rt = REQ_CONSUME;
        end
        send_item(rt, kc, kv, cm, 1'b0, RES_ZERO);
      end
    end
    calm = 1'b0;

    settle();
    repeat (8) @(negedge clk);
    $display("Sent %0d input beats across %0d register settings; %0d result beats checked.",
             beats_in, settings, reports_seen);
    $display("Repeat steps fired: %0d, clamped volume updates: %0d, mismatches: %0d.",
             repeat_steps, clamped, mismatches);
    if (mismatches == 0 && latch_reports.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/core/kel_pkg.sv
rtl/core/kel_cfg.sv
rtl/core/kel_core.sv
rtl/core/key_event_latch_typematic.sv
tb/testbench.sv
